@@ sv/u8dnc_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dnc_pkg
// Shared types, constants and a helper function for the display name checker.
// ----------------------------------------------------------------------------
package u8dnc_pkg;

  // Register map: one 8-bit limit register at word index 0.
  localparam int unsigned CfgAddrW        = 3;
  localparam int unsigned CfgDataW        = 32;
  localparam logic        CFG_IDX_MAX_LEN = 1'b0;
  localparam logic [7:0]  MAX_LEN_RESET   = 8'd35;

  // Byte classes and limits used by the decoder.
  localparam logic [7:0]  BYTE_SPACE      = 8'h20;
  localparam logic [7:0]  BYTE_DEL        = 8'h7f;
  localparam logic [7:0]  BYTE_LEAD2_LO   = 8'hc2;
  localparam logic [7:0]  BYTE_LEAD2_HI   = 8'hdf;
  localparam logic [7:0]  BYTE_LEAD3_LO   = 8'he0;
  localparam logic [7:0]  BYTE_LEAD3_HI   = 8'hef;
  localparam logic [7:0]  BYTE_LEAD4_LO   = 8'hf0;
  localparam logic [7:0]  BYTE_LEAD4_HI   = 8'hf4;
  localparam logic [7:0]  COUNT_SAT       = 8'hff;

  localparam logic [20:0] CP_MIN_3BYTE    = 21'h000800;
  localparam logic [20:0] CP_MIN_4BYTE    = 21'h010000;
  localparam logic [20:0] CP_MAX          = 21'h10ffff;
  localparam logic [20:0] CP_SURR_LO      = 21'h00d800;
  localparam logic [20:0] CP_SURR_HI      = 21'h00dfff;
  localparam logic [20:0] CP_C1_LO        = 21'h000080;
  localparam logic [20:0] CP_C1_HI        = 21'h00009f;

  // Kind of multi-byte sequence in progress.
  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } seq_kind_t;

  // Per-name decoder state.
  typedef struct packed {
    logic [7:0]  bytes_seen;
    logic [1:0]  cont_left;
    seq_kind_t   seq_kind;
    logic [20:0] partial_cp;
    logic        failed;
    logic        prev_space;
  } name_state_t;

  // Verdict given on an end marker.
  typedef struct packed {
    logic [7:0] byte_count;
    logic       name_valid;
  } verdict_t;

  // True when a completed code point is acceptable for its sequence kind.
  function automatic logic codepoint_ok(seq_kind_t kind, logic [20:0] cp);
    logic ok;
    ok = 1'b1;
    if (kind == SEQ_THREE && cp < CP_MIN_3BYTE) ok = 1'b0;
    if (kind == SEQ_FOUR && cp < CP_MIN_4BYTE) ok = 1'b0;
    if (cp > CP_MAX) ok = 1'b0;
    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ok = 1'b0;
    if (cp >= CP_C1_LO && cp <= CP_C1_HI) ok = 1'b0;
    return ok;
  endfunction

endpackage

@@ sv/utf8_display_name_checker_core.sv @@
// ----------------------------------------------------------------------------
// utf8_display_name_checker_core
// Streaming UTF-8 display name checker with an APB limit register.
// ----------------------------------------------------------------------------
// Bytes of a name arrive one per beat on the in_ stream with in_tuser low; a
// beat with in_tuser high ends the name and produces exactly one verdict beat
// on the out_ stream. The block accepts one beat every cycle: each beat is
// captured in an input register, the decoder update is a single short pass of
// logic, and the verdict lands in an output register, so an end marker passes
// both registers before its verdict is on out_tvalid. The input only stalls
// when an end marker waits behind a verdict that the sink has not taken yet.
// Byte beats produce no output. The length limit is written through the cfg_
// port at address 0 and must only be changed while no name is in flight.
module utf8_display_name_checker_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] name_byte
  input  logic                               in_tuser,   // [0] end_of_name
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [0] name_valid,
                                                         // [8:1] byte_count,
                                                         // [15:9] zero
  // Configuration port.
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [u8dnc_pkg::CfgAddrW-1:0]     cfg_paddr,
  input  logic [u8dnc_pkg::CfgDataW-1:0]     cfg_pwdata,
  output logic [u8dnc_pkg::CfgDataW-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import u8dnc_pkg::*;

  logic        [7:0] max_len;
  logic              stg_valid_r;
  logic        [7:0] stg_byte_r;
  logic              stg_eon_r;
  logic              stg_go;
  name_state_t       state_r;
  name_state_t       state_nxt;
  verdict_t          verdict;
  logic              out_valid_r;
  verdict_t          out_data_r;

  u8dnc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_len     (max_len)
  );

  u8dnc_step u_step (
    .st          (state_r),
    .name_byte   (stg_byte_r),
    .end_of_name (stg_eon_r),
    .max_len     (max_len),
    .st_nxt      (state_nxt),
    .verdict     (verdict)
  );

  // A staged byte always retires; an end marker needs room in the output.
  assign stg_go    = stg_valid_r && (!stg_eon_r || !out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || stg_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
      stg_eon_r  <= in_tuser;
    end
  end

  // Decoder state advances when the staged beat retires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (stg_go) begin
      state_r <= state_nxt;
    end
  end

  // Output register holding the verdict until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_go && stg_eon_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && stg_eon_r) begin
      out_data_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r.byte_count, out_data_r.name_valid};

endmodule

@@ sv/u8dnc_cfg.sv @@
// ----------------------------------------------------------------------------
// u8dnc_cfg
// APB-style register block holding the maximum name length.
// ----------------------------------------------------------------------------
module u8dnc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [u8dnc_pkg::CfgAddrW-1:0]     cfg_paddr,
  input  logic [u8dnc_pkg::CfgDataW-1:0]     cfg_pwdata,
  output logic [u8dnc_pkg::CfgDataW-1:0]     cfg_prdata,
  output logic                               cfg_pready,
  output logic [7:0]                         max_len
);
  import u8dnc_pkg::*;

  logic       reg_hit;
  logic       wr_en;
  logic [7:0] max_len_r;
  logic [7:0] max_len_nxt;

  // Word index is the top address bit; low bits select bytes and are ignored.
  assign reg_hit    = (cfg_paddr[CfgAddrW-1] == CFG_IDX_MAX_LEN);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && reg_hit;
  assign cfg_pready = 1'b1;

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en) begin
      max_len_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  // Read data: the limit zero-extended, zero for unmapped words.
  assign cfg_prdata = reg_hit ? {{(CfgDataW-8){1'b0}}, max_len_r} : '0;
  assign max_len    = max_len_r;

endmodule

@@ sv/u8dnc_step.sv @@
// ----------------------------------------------------------------------------
// u8dnc_step
// Combinational next-state and verdict logic for one input beat.
// ----------------------------------------------------------------------------
module u8dnc_step (
  input  u8dnc_pkg::name_state_t st,
  input  logic [7:0]             name_byte,
  input  logic                   end_of_name,
  input  logic [7:0]             max_len,
  output u8dnc_pkg::name_state_t st_nxt,
  output u8dnc_pkg::verdict_t    verdict
);
  import u8dnc_pkg::*;

  logic [20:0] cp_shift;
  logic [1:0]  cont_dec;

  assign cp_shift = {st.partial_cp[14:0], name_byte[5:0]};
  assign cont_dec = st.cont_left - 2'd1;

  // Verdict on the state as it stands before the end marker.
  always_comb begin
    verdict.byte_count = st.bytes_seen;
    verdict.name_valid = !st.failed
                      && (st.bytes_seen != 8'd0)
                      && (st.bytes_seen != COUNT_SAT)
                      && (st.bytes_seen <= max_len)
                      && !st.prev_space
                      && (st.cont_left == 2'd0);
  end

  // Decoder update for a byte beat; an end marker clears the name.
  always_comb begin
    st_nxt = st;
    if (end_of_name) begin
      st_nxt = '0;
    end else begin
      if (st.bytes_seen == 8'd0 && name_byte == BYTE_SPACE) st_nxt.failed = 1'b1;
      if (st.bytes_seen != COUNT_SAT) st_nxt.bytes_seen = st.bytes_seen + 8'd1;
      st_nxt.prev_space = (name_byte == BYTE_SPACE);

      if (st.cont_left != 2'd0) begin
        // Inside a sequence: expect a continuation byte.
        if (name_byte[7:6] != 2'b10) begin
          st_nxt.failed     = 1'b1;
          st_nxt.cont_left  = 2'd0;
          st_nxt.seq_kind   = SEQ_NONE;
          st_nxt.partial_cp = '0;
        end else begin
          st_nxt.cont_left  = cont_dec;
          st_nxt.partial_cp = cp_shift;
          if (cont_dec == 2'd0) begin
            if (!codepoint_ok(st.seq_kind, cp_shift)) st_nxt.failed = 1'b1;
            st_nxt.seq_kind   = SEQ_NONE;
            st_nxt.partial_cp = '0;
          end
        end
      end else begin
        // Outside a sequence: classify the byte.
        priority if (name_byte <= BYTE_DEL) begin
          if (name_byte < BYTE_SPACE || name_byte == BYTE_DEL) st_nxt.failed = 1'b1;
        end else if (name_byte >= BYTE_LEAD2_LO && name_byte <= BYTE_LEAD2_HI) begin
          st_nxt.seq_kind   = SEQ_TWO;
          st_nxt.cont_left  = 2'd1;
          st_nxt.partial_cp = {16'd0, name_byte[4:0]};
        end else if (name_byte >= BYTE_LEAD3_LO && name_byte <= BYTE_LEAD3_HI) begin
          st_nxt.seq_kind   = SEQ_THREE;
          st_nxt.cont_left  = 2'd2;
          st_nxt.partial_cp = {17'd0, name_byte[3:0]};
        end else if (name_byte >= BYTE_LEAD4_LO && name_byte <= BYTE_LEAD4_HI) begin
          st_nxt.seq_kind   = SEQ_FOUR;
          st_nxt.cont_left  = 2'd3;
          st_nxt.partial_cp = {18'd0, name_byte[2:0]};
        end else begin
          st_nxt.failed     = 1'b1;
          st_nxt.cont_left  = 2'd0;
          st_nxt.seq_kind   = SEQ_NONE;
          st_nxt.partial_cp = '0;
        end
      end
    end
  end

endmodule

@@ sv/u8dnc_checker.sv @@
// ----------------------------------------------------------------------------
// u8dnc_checker
// Port-level assertions for the display name checker, bound to the top level.
// ----------------------------------------------------------------------------
module u8dnc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled verdict beat stays up and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict beat dropped or changed while stalled");

  // No verdict is shown in the cycle after a reset edge.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("verdict beat present right after reset");

  // A passing name has at least one byte and an unsaturated count.
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[8:1] != 8'd0 && out_tdata[8:1] != 8'hff)
    else $error("passing verdict with empty or saturated byte count");

  // Padding bits of a verdict beat are zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == 7'd0)
    else $error("verdict padding bits not zero");

endmodule

bind utf8_display_name_checker_core u8dnc_checker u_u8dnc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
